// ===== rtl/bmci_pkg.sv =====
// Package for the bank mapper with cycle IRQ counter.
// Holds the beat structs, request and command codes, and reset constants.
// Depends on nothing; used by the top-level module.
package bmci_pkg;

    // Request kinds carried in the func field.
    typedef enum logic [1:0] {
        FUNC_CPU_WRITE     = 2'd0,
        FUNC_CPU_TICK      = 2'd1,
        FUNC_CPU_TRANSLATE = 2'd2,
        FUNC_PPU_TRANSLATE = 2'd3
    } func_t;

    // Commands latched by a write to the command window.
    localparam logic [3:0] CMD_PRG0       = 4'd8;
    localparam logic [3:0] CMD_PRG1       = 4'd9;
    localparam logic [3:0] CMD_PRG2       = 4'd10;
    localparam logic [3:0] CMD_PRG3       = 4'd11;
    localparam logic [3:0] CMD_MIRROR     = 4'd12;
    localparam logic [3:0] CMD_IRQ_CTRL   = 4'd13;
    localparam logic [3:0] CMD_COUNT_LO   = 4'd14;
    localparam logic [3:0] CMD_COUNT_HI   = 4'd15;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAST_PRG_BANK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_MIRROR   = 2'd1;

    // Address windows (upper three address bits select an 8K window).
    localparam logic [2:0]  WIN_COMMAND   = 3'b100;  // 0x8000-0x9FFF
    localparam logic [2:0]  WIN_ARGUMENT  = 3'b101;  // 0xA000-0xBFFF
    localparam logic [2:0]  WIN_FIXED     = 3'b111;  // 0xE000-0xFFFF
    localparam logic [15:0] CPU_MAP_BASE  = 16'h6000;
    localparam logic [15:0] CPU_ROM_BASE  = 16'h8000;
    localparam logic [15:0] PPU_MAP_LIMIT = 16'h2000;

    // Reset values.
    localparam logic [7:0] LAST_PRG_BANK_RESET = 8'd255;
    localparam logic [1:0] INIT_MIRROR_RESET   = 2'd0;

    // Input beat.
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] address;
        logic [7:0]  data;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic        mapped;
        logic [7:0]  bank;
        logic [12:0] offset;
        logic        is_ram;
        logic        irq_line;
        logic [1:0]  mirror_mode;
    } out_beat_t;

endpackage

// ===== rtl/bank_mapper_with_cycle_irq_unit.sv =====
// Usage notes for the bank mapper with cycle IRQ counter.
//
// Input channel (in_valid, in_stall, in_item): one beat is a CPU write, a CPU
// cycle tick, a CPU address translate or a PPU address translate. Output
// channel (out_valid, out_stall, out_item): exactly one result beat per input
// beat, in order, carrying the translation, the IRQ level and the mirroring
// mode as they stand after that input beat.
// The mapper state and the result register update at the edge that accepts
// the beat. Throughput is one beat per clock while the receiver does not
// stall, set by the single result register; a new beat is taken in the same
// cycle the previous result leaves.
// When the receiver stalls with a result waiting, in_stall rises and the
// held result stays unchanged until it is taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 sets the fixed last PRG bank, index 1 the initial
// mirroring mode, which is written straight into the live mirroring register.
// Other indexes are ignored.
// Reset (rst_n low, asynchronous) restores all banks, counters and enables
// to their power-on values and empties the result register.

// Top level: the whole mapper, one register stage.
// Depends on bmci_pkg.
module bank_mapper_with_cycle_irq_unit
    import bmci_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_beat_t               in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_beat_t              out_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    // Mapper state.
    logic [7:0]  last_prg_bank_reg, last_prg_bank_next;
    logic [3:0]  command_reg, command_next;
    logic [7:0]  prg_bank_reg [4];
    logic [7:0]  prg_bank_next [4];
    logic [7:0]  chr_bank_reg [8];
    logic [7:0]  chr_bank_next [8];
    logic        ram_select_reg, ram_select_next;
    logic        ram_enable_reg, ram_enable_next;
    logic [1:0]  mirroring_reg, mirroring_next;
    logic        irq_enable_reg, irq_enable_next;
    logic        count_enable_reg, count_enable_next;
    logic [15:0] irq_counter_reg, irq_counter_next;
    logic        irq_pending_reg, irq_pending_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_item_reg, out_item_next;

    logic        in_accept;
    logic        cfg_accept;
    func_t       func;
    logic [15:0] addr;
    logic [2:0]  win;
    logic [15:0] prg_rel;
    logic [1:0]  prg_sel;
    logic [2:0]  chr_sel;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid & cfg_ready;
    assign in_stall   = out_valid_reg & out_stall;
    assign in_accept  = in_valid & ~in_stall;
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    assign func    = func_t'(in_item.func);
    assign addr    = in_item.address;
    assign win     = addr[15:13];
    assign prg_rel = addr - CPU_MAP_BASE;
    assign prg_sel = prg_rel[14:13];
    assign chr_sel = addr[12:10];

    // Next state of the mapper registers for the accepted beat.
    always_comb
    begin
        last_prg_bank_next = last_prg_bank_reg;
        command_next       = command_reg;
        prg_bank_next      = prg_bank_reg;
        chr_bank_next      = chr_bank_reg;
        ram_select_next    = ram_select_reg;
        ram_enable_next    = ram_enable_reg;
        mirroring_next     = mirroring_reg;
        irq_enable_next    = irq_enable_reg;
        count_enable_next  = count_enable_reg;
        irq_counter_next   = irq_counter_reg;
        irq_pending_next   = irq_pending_reg;

        if (cfg_accept)
        begin
            if (cfg_index == CFG_LAST_PRG_BANK)
            begin
                last_prg_bank_next = cfg_data;
            end
            else if (cfg_index == CFG_INIT_MIRROR)
            begin
                mirroring_next = cfg_data[1:0];
            end
        end

        if (in_accept)
        begin
            unique case (func)
                FUNC_CPU_WRITE:
                begin
                    if (win == WIN_COMMAND)
                    begin
                        command_next = in_item.data[3:0];
                    end
                    else if (win == WIN_ARGUMENT)
                    begin
                        // Commands 0 to 7 select a CHR 1K bank.
                        if (!command_reg[3])
                        begin
                            chr_bank_next[command_reg[2:0]] = in_item.data;
                        end
                        else
                        begin
                            unique case (command_reg)
                                CMD_PRG0:
                                begin
                                    prg_bank_next[0] = in_item.data;
                                    ram_select_next  = in_item.data[6];
                                    ram_enable_next  = in_item.data[7];
                                end
                                CMD_PRG1, CMD_PRG2, CMD_PRG3:
                                begin
                                    prg_bank_next[command_reg[1:0]] = in_item.data;
                                end
                                CMD_MIRROR:
                                begin
                                    mirroring_next = in_item.data[1:0];
                                end
                                CMD_IRQ_CTRL:
                                begin
                                    irq_enable_next   = in_item.data[0];
                                    count_enable_next = in_item.data[7];
                                    irq_pending_next  = 1'b0;
                                end
                                CMD_COUNT_LO:
                                begin
                                    irq_counter_next[7:0] = in_item.data;
                                end
                                CMD_COUNT_HI:
                                begin
                                    irq_counter_next[15:8] = in_item.data;
                                end
                                default:
                                begin
                                    irq_counter_next = irq_counter_reg;
                                end
                            endcase
                        end
                    end
                end
                FUNC_CPU_TICK:
                begin
                    // While IRQ and counting are both enabled, decrement; a wrap from zero raises the IRQ.
                    if (irq_enable_reg && count_enable_reg)
                    begin
                        irq_counter_next = irq_counter_reg - 16'd1;
                        if (irq_counter_reg == 16'd0)
                        begin
                            irq_pending_next = 1'b1;
                        end
                    end
                end
                FUNC_CPU_TRANSLATE, FUNC_PPU_TRANSLATE:
                begin
                    // Translates leave the state alone.
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result beat for the accepted item, and the output handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (in_accept)
        begin
            out_valid_next            = 1'b1;
            out_item_next.mapped      = 1'b0;
            out_item_next.bank        = 8'd0;
            out_item_next.offset      = 13'd0;
            out_item_next.is_ram      = 1'b0;
            out_item_next.irq_line    = irq_pending_next;
            out_item_next.mirror_mode = mirroring_next;

            if (func == FUNC_CPU_TRANSLATE)
            begin
                if (addr >= CPU_MAP_BASE)
                begin
                    out_item_next.mapped = 1'b1;
                    out_item_next.offset = addr[12:0];
                    if (win == WIN_FIXED)
                    begin
                        out_item_next.bank = last_prg_bank_reg;
                    end
                    else if (addr < CPU_ROM_BASE && ram_select_reg && ram_enable_reg)
                    begin
                        out_item_next.is_ram = 1'b1;
                    end
                    else
                    begin
                        out_item_next.bank = prg_bank_reg[prg_sel];
                    end
                end
            end
            else if (func == FUNC_PPU_TRANSLATE)
            begin
                if (addr < PPU_MAP_LIMIT)
                begin
                    out_item_next.mapped = 1'b1;
                    out_item_next.offset = {3'd0, addr[9:0]};
                    out_item_next.bank   = chr_bank_reg[chr_sel];
                end
            end
        end
    end

    // Control and mapper state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_prg_bank_reg <= LAST_PRG_BANK_RESET;
            command_reg       <= 4'd0;
            for (int i = 0; i < 4; i++)
            begin
                prg_bank_reg[i] <= 8'(i);
            end
            for (int i = 0; i < 8; i++)
            begin
                chr_bank_reg[i] <= 8'd0;
            end
            ram_select_reg    <= 1'b0;
            ram_enable_reg    <= 1'b0;
            mirroring_reg     <= INIT_MIRROR_RESET;
            irq_enable_reg    <= 1'b0;
            count_enable_reg  <= 1'b0;
            irq_counter_reg   <= 16'd0;
            irq_pending_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            last_prg_bank_reg <= last_prg_bank_next;
            command_reg       <= command_next;
            prg_bank_reg      <= prg_bank_next;
            chr_bank_reg      <= chr_bank_next;
            ram_select_reg    <= ram_select_next;
            ram_enable_reg    <= ram_enable_next;
            mirroring_reg     <= mirroring_next;
            irq_enable_reg    <= irq_enable_next;
            count_enable_reg  <= count_enable_next;
            irq_counter_reg   <= irq_counter_next;
            irq_pending_reg   <= irq_pending_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result payload register; no reset needed.
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule
